// ----- hw/rtl/tsd_pkg.sv -----
// Shared types and constants for the tick scheduler with sprite DMA.
// Used by every module under hw/rtl; depends on nothing.
package tsd_pkg;

    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 40;
    localparam int unsigned RATE_W     = 18;
    localparam int unsigned PHASE_W    = 23;
    localparam int unsigned SLOT_W     = 3;

    localparam logic [RATE_W-1:0]  AUDIO_RATE_RESET = 18'd44100;
    localparam logic [PHASE_W-1:0] VIDEO_CLOCK_HZ   = 23'd5369318;

    localparam logic [SLOT_W-1:0] SLOT_EVEN = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_ODD  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd5;

    localparam logic [7:0] INDEX_LAST = 8'hFF;

    typedef enum logic {
        OP_TICK       = 1'b0,
        OP_PAGE_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        logic        cpu_enable;
        logic        read_request;
        logic [15:0] read_address;
        logic        sprite_write;
        logic [7:0]  sprite_index;
        logic [7:0]  sprite_byte;
        logic        dma_busy;
    } dma_out_t;

endpackage

// ----- hw/rtl/tick_scheduler_with_sprite_dma.sv -----
// Top level: master tick scheduler with sprite DMA and audio pacing.
// A tick result is registered and is valid in the cycle after its input transfer.
// Throughput: one input item per cycle; the result register lets the next
// item enter while m_tready is high or the register is empty.
// Page writes produce no result. Reset (aresetn low, synchronous) clears
// all state except m_data_reg and loads the sample rate register with 44100.
module tick_scheduler_with_sprite_dma (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsd_pkg::RATE_W-1:0]    cfg_data,     // audio_rate
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tsd_pkg::S_TDATA_W-1:0] s_tdata,      // page[7:0], read_data[15:8]
    input  logic                          s_tuser,      // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // video_enable[0], cpu_enable[1], read_request[2], read_address[18:3],
    // sprite_write[19], sprite_index[27:20], sprite_byte[35:28],
    // audio_ready[36], dma_busy[37], zero[39:38]
    output logic [tsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import tsd_pkg::*;

    logic                 s_accept;
    logic                 tick_en;
    logic                 page_en;
    dma_out_t             dma_out;
    logic                 audio_ready;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign tick_en   = s_accept && (op_t'(s_tuser) == OP_TICK);
    assign page_en   = s_accept && (op_t'(s_tuser) == OP_PAGE_WRITE);

    tsd_dma u_dma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (tick_en),
        .page_en   (page_en),
        .page      (s_tdata[7:0]),
        .read_data (s_tdata[15:8]),
        .dma_out   (dma_out)
    );

    tsd_audio u_audio (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_en      (cfg_valid),
        .cfg_data    (cfg_data),
        .tick_en     (tick_en),
        .audio_ready (audio_ready)
    );

    assign result = {2'b00, dma_out.dma_busy, audio_ready, dma_out.sprite_byte,
                     dma_out.sprite_index, dma_out.sprite_write,
                     dma_out.read_address, dma_out.read_request,
                     dma_out.cpu_enable, 1'b1};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (tick_en) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- hw/rtl/tsd_dma.sv -----
// Tick slot counter and sprite DMA sequencer.
// Depends on tsd_pkg.
module tsd_dma (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick_en,
    input  logic               page_en,
    input  logic [7:0]         page,
    input  logic [7:0]         read_data,
    output tsd_pkg::dma_out_t  dma_out
);
    import tsd_pkg::*;

    logic [SLOT_W-1:0] phase_count_reg, phase_count_next;
    logic [7:0]        source_page_reg, source_page_next;
    logic [7:0]        transfer_index_reg, transfer_index_next;
    logic [7:0]        held_byte_reg, held_byte_next;
    logic              awaiting_reg, awaiting_next;
    logic              active_reg, active_next;
    logic              outstanding_reg, outstanding_next;
    logic [7:0]        held_eff;
    logic              slot;
    logic              odd;

    always_comb begin
        held_eff = outstanding_reg ? read_data : held_byte_reg;
        slot     = (phase_count_reg == SLOT_EVEN) || (phase_count_reg == SLOT_ODD);
        odd      = (phase_count_reg == SLOT_ODD);

        phase_count_next    = phase_count_reg;
        source_page_next    = source_page_reg;
        transfer_index_next = transfer_index_reg;
        held_byte_next      = held_byte_reg;
        awaiting_next       = awaiting_reg;
        active_next         = active_reg;
        outstanding_next    = outstanding_reg;

        dma_out              = '0;
        dma_out.dma_busy     = active_reg;

        if (slot) begin
            if (active_reg) begin
                if (!awaiting_reg && !odd) begin
                    dma_out.read_request = 1'b1;
                    dma_out.read_address = {source_page_reg, transfer_index_reg};
                end else if (!awaiting_reg && odd) begin
                    dma_out.sprite_write = 1'b1;
                    dma_out.sprite_index = transfer_index_reg;
                    dma_out.sprite_byte  = held_eff;
                end
            end else begin
                dma_out.cpu_enable = 1'b1;
            end
        end

        if (page_en) begin
            source_page_next    = page;
            transfer_index_next = 8'd0;
            active_next         = 1'b1;
        end else if (tick_en) begin
            held_byte_next   = held_eff;
            outstanding_next = 1'b0;
            if (slot && active_reg) begin
                if (awaiting_reg) begin
                    if (odd) begin
                        awaiting_next = 1'b0;
                    end
                end else if (!odd) begin
                    outstanding_next = 1'b1;
                end else begin
                    transfer_index_next = transfer_index_reg + 8'd1;
                    if (transfer_index_reg == INDEX_LAST) begin
                        active_next   = 1'b0;
                        awaiting_next = 1'b1;
                    end
                end
            end
            phase_count_next = (phase_count_reg == SLOT_LAST) ? '0
                             : phase_count_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_reg    <= '0;
            source_page_reg    <= '0;
            transfer_index_reg <= '0;
            held_byte_reg      <= '0;
            awaiting_reg       <= 1'b1;
            active_reg         <= 1'b0;
            outstanding_reg    <= 1'b0;
        end else begin
            phase_count_reg    <= phase_count_next;
            source_page_reg    <= source_page_next;
            transfer_index_reg <= transfer_index_next;
            held_byte_reg      <= held_byte_next;
            awaiting_reg       <= awaiting_next;
            active_reg         <= active_next;
            outstanding_reg    <= outstanding_next;
        end
    end

endmodule

// ----- hw/rtl/tsd_audio.sv -----
// Audio sample pacing: sample rate register and phase accumulator.
// Depends on tsd_pkg.
module tsd_audio (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_en,
    input  logic [tsd_pkg::RATE_W-1:0] cfg_data,
    input  logic                       tick_en,
    output logic                       audio_ready
);
    import tsd_pkg::*;

    logic [RATE_W-1:0]  audio_rate_reg;
    logic [PHASE_W-1:0] audio_phase_reg, audio_phase_next;
    logic [PHASE_W:0]   sum;

    always_comb begin
        sum         = {1'b0, audio_phase_reg} + (PHASE_W + 1)'(audio_rate_reg);
        audio_ready = (sum >= {1'b0, VIDEO_CLOCK_HZ});
        audio_phase_next = audio_ready ? PHASE_W'(sum - {1'b0, VIDEO_CLOCK_HZ})
                                       : sum[PHASE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_rate_reg  <= AUDIO_RATE_RESET;
            audio_phase_reg <= '0;
        end else begin
            if (cfg_en) begin
                audio_rate_reg <= cfg_data;
            end
            if (tick_en) begin
                audio_phase_reg <= audio_phase_next;
            end
        end
    end

endmodule

// ----- hw/rtl/tsd_checker.sv -----
// Port-level checks for tick_scheduler_with_sprite_dma, attached by bind.
// Depends on tsd_pkg.
module tsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import tsd_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_video: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] && (m_tdata[39:38] == 2'b00))
        else $error("video enable low or pad bits set");

    a_cpu_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2] || m_tdata[19]) |-> !m_tdata[1] && m_tdata[37]
                                                   && !(m_tdata[2] && m_tdata[19]))
        else $error("DMA slot overlaps processor slot or idle DMA");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] || (m_tdata[18:3] == 16'd0))
                  && (m_tdata[19] || (m_tdata[35:20] == 16'd0)))
        else $error("unused DMA fields not zero");

endmodule

bind tick_scheduler_with_sprite_dma tsd_checker u_tsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
